>>> rtl/core/random_disk_packing_placer_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the random disk packing placer
// Checks are compiled in simulation and drop out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef RANDOM_DISK_PACKING_PLACER_DEFINES_SVH
`define RANDOM_DISK_PACKING_PLACER_DEFINES_SVH

`ifndef SYNTH
// condition holds at every edge out of reset
`define RDP_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rdp check failed");
// consequence holds in the same cycle
`define RDP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rdp check failed");
// consequence holds in the following cycle
`define RDP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rdp check failed");
`else
`define RDP_ASSERT_ALWAYS(lbl, cond)
`define RDP_ASSERT_SAME(lbl, ante, cons)
`define RDP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/rdp_pkg.sv
// ---------------------------------------------------------------------------
// rdp_pkg
// Types, register indexes, reset values and status codes of the placer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdp_pkg;

  // disk table capacity default
  localparam int MAX_DISKS_DEF = 512;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_FIELD_SIZE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DISK_RADIUS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_MISSES  = 2'd2;

  // register reset values
  localparam logic [9:0]  FIELD_SIZE_RST  = 10'd775;
  localparam logic [7:0]  DISK_RADIUS_RST = 8'd20;
  localparam logic [15:0] MAX_MISSES_RST  = 16'd1000;

  // stream widths
  localparam int IN_W  = 32;
  localparam int OUT_W = 48;

  // result status codes
  localparam logic [1:0] ST_PLACED   = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_GAVE_UP  = 2'd2;
  localparam logic [1:0] ST_DONE     = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

endpackage

>>> rtl/core/random_disk_packing_placer.sv
// ---------------------------------------------------------------------------
// random_disk_packing_placer
// Random sequential disk packing: scales a random pair to a candidate
// centre, tests it against every stored disk and stores it if clear.
// ---------------------------------------------------------------------------
// Channel   Dir  Handshake               Content
// s_axis    in   tvalid/tready           rand_x, rand_y
// m_axis    out  tvalid/tready           status, cand_x, cand_y, placed_count
// cfg       in   cfg_we (no wait)        field_size, disk_radius, max_misses
//
// Each item runs through accept, scale, scan, drain and decide before the next
// accept, and the scan and drain are skipped once the block finishes: the disk
// table sits in one memory with one read port, scanned one entry per cycle,
// followed by a three-stage distance pipeline that drains before the decision.
// Reset is synchronous; the table needs no clearing pass, only the count.
// A stalled result is held in the output register while the next item is
// accepted; the new result waits in the decide state until that slot frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "random_disk_packing_placer_defines.svh"

module random_disk_packing_placer #(
  parameter int MAX_DISKS = rdp_pkg::MAX_DISKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rdp_pkg::IN_W-1:0]      s_axis_tdata,   // rand_x[15:0], rand_y[31:16]
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rdp_pkg::OUT_W-1:0]     m_axis_tdata,   // status[1:0], cand_x[17:2],
                                                        // cand_y[33:18],
                                                        // placed_count[43:34], zero[47:44]
  // configuration writes
  input  logic                          cfg_we,
  input  logic [rdp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rdp_pkg::CFG_DATA_W-1:0] cfg_data
);

  import rdp_pkg::*;

  localparam int AW    = $clog2(MAX_DISKS);
  localparam int CNT_W = $clog2(MAX_DISKS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DISKS);

  // configuration registers
  logic [9:0]  field_size;
  logic [7:0]  disk_radius;
  logic [15:0] max_misses;

  // control state
  state_t           state, state_next;
  logic [CNT_W-1:0] disk_count;
  logic [16:0]      miss_count;
  logic             finished;
  logic [CNT_W-1:0] rd_idx;
  logic             hit;

  // item registers
  logic [15:0] in_x, in_y;
  logic [15:0] cand_x, cand_y;
  logic [29:0] thr;

  // disk table, x in the low half
  logic [31:0] disk_mem [MAX_DISKS];
  logic [31:0] mem_q;
  logic        rd_en, wr_en;

  // distance pipeline
  logic        v_rd, v1, v2;
  logic [15:0] dx, dy;
  logic [31:0] sq_x, sq_y;

  // output register
  logic        out_valid;
  logic [OUT_W-1:0] out_data;

  // control strobes
  logic             accept, load_out, out_free;
  logic             do_scale, scan_start;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      field_size  <= FIELD_SIZE_RST;
      disk_radius <= DISK_RADIUS_RST;
      max_misses  <= MAX_MISSES_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FIELD_SIZE:  field_size  <= cfg_data[9:0];
        REG_DISK_RADIUS: disk_radius <= cfg_data[7:0];
        REG_MAX_MISSES:  max_misses  <= cfg_data;
        default: ;
      endcase
    end
  end

  // candidate scaling
  logic [8:0]  two_r;
  logic [9:0]  span;
  logic [25:0] prod_x, prod_y;
  logic [15:0] r_q6;
  logic [15:0] r_sq;

  always_comb begin
    two_r  = {disk_radius, 1'b0};
    span   = ({1'b0, field_size} > {2'b0, two_r}) ?
             (field_size - {1'b0, two_r}) : 10'd0;
    prod_x = {10'd0, in_x} * {16'd0, span};
    prod_y = {10'd0, in_y} * {16'd0, span};
    r_q6   = {2'b0, disk_radius, 6'b0};
    r_sq   = {8'd0, disk_radius} * {8'd0, disk_radius};
  end

  // decision logic
  logic [16:0]      miss_inc;
  logic             give_up;
  logic             placed;
  logic [CNT_W-1:0] count_after;
  logic [CNT_W+9:0] count_wide;
  logic [1:0]       status;
  logic [15:0]      res_x, res_y;

  always_comb begin
    miss_inc    = miss_count + 17'd1;
    give_up     = miss_inc > {1'b0, max_misses};
    placed      = !finished && !hit;
    count_after = placed ? disk_count + CNT_W'(1) : disk_count;
    count_wide  = {10'd0, count_after};
    if (finished) begin
      status = ST_DONE;
    end else if (!hit) begin
      status = ST_PLACED;
    end else if (give_up) begin
      status = ST_GAVE_UP;
    end else begin
      status = ST_REJECTED;
    end
    res_x = finished ? 16'd0 : cand_x;
    res_y = finished ? 16'd0 : cand_y;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    accept     = 1'b0;
    do_scale   = 1'b0;
    scan_start = 1'b0;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    out_free   = !out_valid || m_axis_tready;
    case (state)
      S_IDLE: begin
        accept = s_axis_tvalid;
        if (s_axis_tvalid) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        do_scale   = 1'b1;
        scan_start = 1'b1;
        state_next = finished ? S_DECIDE : S_SCAN;
      end
      S_SCAN: begin
        if (rd_idx < disk_count) begin
          rd_en = 1'b1;
        end else begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v_rd && !v1 && !v2) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);
  assign wr_en = load_out && placed;

  // item capture, candidate and threshold
  always_ff @(posedge clk) begin
    if (accept) begin
      in_x <= s_axis_tdata[15:0];
      in_y <= s_axis_tdata[31:16];
    end
    if (do_scale) begin
      cand_x <= r_q6 + prod_x[25:10];
      cand_y <= r_q6 + prod_y[25:10];
      thr    <= {r_sq, 14'd0};
    end
  end

  // scan index and hit flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      hit    <= 1'b0;
    end else begin
      if (scan_start) begin
        rd_idx <= '0;
        hit    <= 1'b0;
      end else if (rd_en) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      if (v2 && (({1'b0, sq_x} + {1'b0, sq_y}) < {3'd0, thr})) begin
        hit <= 1'b1;
      end
    end
  end

  // disk table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      disk_mem[disk_count[AW-1:0]] <= {cand_y, cand_x};
    end
    if (rd_en) begin
      mem_q <= disk_mem[rd_idx[AW-1:0]];
    end
  end

  // distance pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v_rd <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
    end else begin
      v_rd <= rd_en;
      v1   <= v_rd;
      v2   <= v1;
    end
  end

  // absolute differences, then squares
  always_ff @(posedge clk) begin
    if (v_rd) begin
      dx <= (mem_q[15:0] > cand_x) ? (mem_q[15:0] - cand_x) : (cand_x - mem_q[15:0]);
      dy <= (mem_q[31:16] > cand_y) ? (mem_q[31:16] - cand_y) : (cand_y - mem_q[31:16]);
    end
    if (v1) begin
      sq_x <= {16'd0, dx} * {16'd0, dx};
      sq_y <= {16'd0, dy} * {16'd0, dy};
    end
  end

  // counters and finished flag
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_count <= '0;
      miss_count <= '0;
      finished   <= 1'b0;
    end else if (load_out && !finished) begin
      disk_count <= count_after;
      if (!hit) begin
        miss_count <= '0;
        if (count_after >= MAX_CNT) begin
          finished <= 1'b1;
        end
      end else begin
        miss_count <= miss_inc;
        if (give_up) begin
          finished <= 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= {4'd0, count_wide[9:0], res_y, res_x, status};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // checks
  `RDP_ASSERT_ALWAYS(a_count_range, disk_count <= MAX_CNT)
  `RDP_ASSERT_SAME(a_read_in_range, rd_en, rd_idx < disk_count)
  `RDP_ASSERT_NEXT(a_finished_sticky, finished, finished)
  `RDP_ASSERT_NEXT(a_place_counts, load_out && placed, disk_count == $past(disk_count) + CNT_W'(1))
  `RDP_ASSERT_SAME(a_done_zero, m_axis_tvalid && (m_axis_tdata[1:0] == ST_DONE), m_axis_tdata[33:2] == 32'd0)

endmodule
